// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rgbd rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- hw/rtl/rgbd_pkg.sv -----
// shared types and constants of the 2x2 rgb box downscaler
// no dependencies
package rgbd_pkg;

    localparam int CFG_DATA_BITS    = 12;
    localparam int ROW_BITS         = 11;
    localparam int HEIGHT_LIMIT     = 2048;
    localparam int NUM_CH           = 3;
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;

    localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 12'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    // per-word control from the position logic
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic last;
    } rgbd_ctrl_t;

endpackage

// ----- hw/rtl/rgbd_pix_if.sv -----
// handshake channel for incoming rgb pixels
// no dependencies
interface rgbd_pix_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

// ----- hw/rtl/rgbd_out_if.sv -----
// handshake channel for halved output pixels
// no dependencies
interface rgbd_out_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic                    frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_last, output ready);
endinterface

// ----- hw/rtl/rgbd_line_mem.sv -----
// line store of horizontal pair sums: one write port, one read port
// registered read data, no dependencies
module rgbd_line_mem #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 27
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read, which covers output stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rgbd_front.sv -----
// size registers, raster position counters, left pixel hold and pair sums
// depends on rgbd_pkg, rgbd_pix_if and assert_macros.svh
`include "assert_macros.svh"

module rgbd_front #(
    parameter int MAX_WIDTH      = rgbd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS   = rgbd_pkg::CHANNEL_BITS_DEF,
    parameter int LINE_ADDR_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  rgbd_pkg::cfg_idx_t                   cfg_index,
    input  logic [rgbd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    rgbd_pix_if.sink                             pixel,
    input  logic                                 slot_free,
    output rgbd_pkg::rgbd_ctrl_t                 ctrl,
    output logic [LINE_ADDR_BITS-1:0]            slot,
    output logic [3*(CHANNEL_BITS+1)-1:0]        pair
);
    import rgbd_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int SW         = (CW > CFG_DATA_BITS) ? CW : CFG_DATA_BITS;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int CB         = CHANNEL_BITS;
    localparam int PB         = CHANNEL_BITS + 1;

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]      col_reg;
    logic [COL_BITS-1:0]      col_next;
    logic [ROW_BITS-1:0]      row_reg;
    logic [ROW_BITS-1:0]      row_next;
    logic [NUM_CH*CB-1:0]     left_reg;

    logic [CB-1:0]            px [NUM_CH];
    logic [SW-1:0]            w_ext;
    logic [SW-1:0]            w_sat;
    logic [CW-1:0]            w;
    logic [CW-1:0]            w_m1;
    logic [CW-1:0]            last_col;
    logic [CW-1:0]            col_ext;
    logic [CFG_DATA_BITS-1:0] h;
    logic [CFG_DATA_BITS-1:0] h_m1;
    logic [CFG_DATA_BITS-1:0] last_row;
    logic [CFG_DATA_BITS-1:0] row_ext;
    logic [COL_BITS-1:0]      half_col;
    logic [COL_BITS-1:0]      masked_col;
    logic                     at_end;
    logic                     row_end;
    logic                     active;
    logic                     accept;

    assign px[0] = pixel.in_red;
    assign px[1] = pixel.in_green;
    assign px[2] = pixel.in_blue;

    assign pixel.ready = slot_free;
    assign accept      = pixel.valid && slot_free;

    always_comb
    begin
        // size registers saturate into the supported range
        w_ext = SW'(width_reg);
        if (w_ext < SW'(2))
        begin
            w_sat = SW'(2);
        end
        else if (w_ext > SW'(MAX_WIDTH))
        begin
            w_sat = SW'(MAX_WIDTH);
        end
        else
        begin
            w_sat = w_ext;
        end
        w = w_sat[CW-1:0];

        if (height_reg < CFG_DATA_BITS'(2))
        begin
            h = CFG_DATA_BITS'(2);
        end
        else if (height_reg > CFG_DATA_BITS'(HEIGHT_LIMIT))
        begin
            h = CFG_DATA_BITS'(HEIGHT_LIMIT);
        end
        else
        begin
            h = height_reg;
        end

        w_m1     = w - CW'(1);
        h_m1     = h - CFG_DATA_BITS'(1);
        last_col = {w[CW-1:1], 1'b0} - CW'(1);
        last_row = {h[CFG_DATA_BITS-1:1], 1'b0} - CFG_DATA_BITS'(1);
        col_ext  = CW'(col_reg);
        row_ext  = CFG_DATA_BITS'(row_reg);
        at_end   = (col_ext >= w_m1);
        row_end  = (row_ext >= h_m1);
        // a trailing odd column does nothing
        active   = !at_end || col_reg[0];

        half_col   = col_reg >> 1;
        masked_col = half_col & COL_BITS'(LINE_DEPTH - 1);
        slot       = masked_col[LINE_ADDR_BITS-1:0];

        for (int c = 0; c < NUM_CH; c++)
        begin
            pair[c*PB +: PB] = PB'(left_reg[c*CB +: CB]) + PB'(px[c]);
        end

        // even rows store pair sums unless this is a trailing odd row
        ctrl.wr_en = accept && active && col_reg[0] && !row_reg[0] && (row_ext < h_m1);
        ctrl.rd_en = accept && active && col_reg[0] && row_reg[0];
        ctrl.last  = (col_ext == last_col) && (row_ext == last_row);

        if (at_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (active && !col_reg[0])
                begin
                    left_reg <= {px[2], px[1], px[0]};
                end
            end
        end
    end

    `ASSERT_NEVER(a_no_rw_same_word, clk, rst_n, ctrl.wr_en && ctrl.rd_en, "line store read and write in one cycle")
    `ASSERT_PROP(a_col_wraps, clk, rst_n, accept && at_end |=> col_reg == COL_BITS'(0), "column did not wrap")
    `ASSERT_PROP(a_col_steps, clk, rst_n, accept && !at_end |=> col_reg == $past(col_reg) + 1'b1, "column did not step")

endmodule

// ----- hw/rtl/rgbd_merge.sv -----
// adds stored pair sums to the current pair, averages, and holds the output word
// depends on rgbd_pkg, rgbd_out_if and assert_macros.svh
`include "assert_macros.svh"

module rgbd_merge #(
    parameter int CHANNEL_BITS = rgbd_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgbd_pkg::rgbd_ctrl_t          ctrl,
    input  logic [3*(CHANNEL_BITS+1)-1:0] pair,
    input  logic [3*(CHANNEL_BITS+1)-1:0] line_data,
    output logic                          slot_free,
    rgbd_out_if.source                    halved
);
    import rgbd_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int PB = CHANNEL_BITS + 1;

    logic                   s1_valid_reg;
    logic [NUM_CH*PB-1:0]   s1_pair_reg;
    logic                   s1_last_reg;
    logic                   s1_adv;
    logic                   out_valid_reg;
    logic [NUM_CH*CB-1:0]   out_pix_reg;
    logic [NUM_CH*CB-1:0]   out_pix_next;
    logic                   out_last_reg;
    logic [PB:0]            sum4;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || halved.ready);
    assign slot_free = !s1_valid_reg || s1_adv;

    always_comb
    begin
        sum4 = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum4 = {1'b0, line_data[c*PB +: PB]} + {1'b0, s1_pair_reg[c*PB +: PB]};
            out_pix_next[c*CB +: CB] = sum4[PB:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // stage 1 waits for the line store read data
            if (ctrl.rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (halved.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            s1_pair_reg <= pair;
            s1_last_reg <= ctrl.last;
        end
        if (s1_adv)
        begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign halved.valid      = out_valid_reg;
    assign halved.out_red    = out_pix_reg[0*CB +: CB];
    assign halved.out_green  = out_pix_reg[1*CB +: CB];
    assign halved.out_blue   = out_pix_reg[2*CB +: CB];
    assign halved.frame_last = out_last_reg;

    `ASSERT_PROP(a_rd_needs_slot, clk, rst_n, ctrl.rd_en |-> slot_free, "word accepted into a busy stage")
    `ASSERT_PROP(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_pair_reg), "stalled stage lost its word")
    `ASSERT_PROP(a_s1_to_out, clk, rst_n, s1_adv |=> out_valid_reg, "advanced word missing at output")

endmodule

// ----- hw/rtl/rgb_2x2_box_downscaler_unit.sv -----
// 2x2 box downscaler for raster-order rgb pixels
// depends on rgbd_pkg, rgbd_pix_if, rgbd_out_if, rgbd_line_mem, rgbd_front, rgbd_merge
//
// Usage: pixels of one frame enter on the pixel channel in raster order, one
// word per valid/ready handshake. Each 2x2 block yields one word on the halved
// channel with the truncated per-channel average; frame_last marks the last
// word of the halved frame. A trailing odd column or row is consumed silently.
// Image size is set by the user through cfg_we/cfg_index/cfg_data while the block
// is idle (not enforced); values are saturated to 2..MAX_WIDTH wide and 2..2048 high.
// Throughput: one pixel per clock while no stall holds pixel.ready low. Each pair
// sum is written to, or read from, the single line store once, on the second pixel
// of the pair; the edge that accepts the last pixel of a block reads the line store
// and loads the read stage, from which the word moves on to the output register
// that presents it valid on the halved channel.
// Reset: counters restart at the top left, sizes return to 640x480; the line
// store is not cleared, as even rows fill it before odd rows read it.
// Stall: when halved.ready is low the output word holds, one more result waits
// in the read stage, and pixel.ready drops only once both are full; pixels
// that produce no result are also held back until then.
module rgb_2x2_box_downscaler_unit #(
    parameter int MAX_WIDTH    = rgbd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = rgbd_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  rgbd_pkg::cfg_idx_t                 cfg_index,
    input  logic [rgbd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    rgbd_pix_if.sink                           pixel,
    rgbd_out_if.source                         halved
);
    import rgbd_pkg::*;

    localparam int LINE_DEPTH     = MAX_WIDTH / 2;
    localparam int LINE_ADDR_BITS = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LINE_BITS      = NUM_CH * (CHANNEL_BITS + 1);

    rgbd_ctrl_t                ctrl;
    logic [LINE_ADDR_BITS-1:0] slot;
    logic [LINE_BITS-1:0]      pair;
    logic [LINE_BITS-1:0]      line_data;
    logic                      slot_free;

    rgbd_front #(
        .MAX_WIDTH      (MAX_WIDTH),
        .CHANNEL_BITS   (CHANNEL_BITS),
        .LINE_ADDR_BITS (LINE_ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .slot_free (slot_free),
        .ctrl      (ctrl),
        .slot      (slot),
        .pair      (pair)
    );

    rgbd_line_mem #(
        .DEPTH     (LINE_DEPTH),
        .ADDR_BITS (LINE_ADDR_BITS),
        .DATA_BITS (LINE_BITS)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (slot),
        .wr_data (pair),
        .rd_en   (ctrl.rd_en),
        .rd_addr (slot),
        .rd_data (line_data)
    );

    rgbd_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pair      (pair),
        .line_data (line_data),
        .slot_free (slot_free),
        .halved    (halved)
    );

endmodule
